[sv/sha1_chain_leading_zero_search_core_defines.svh]
// assertion macros for the sha1 chain search core
`ifndef SHA1_CHAIN_LEADING_ZERO_SEARCH_CORE_DEFINES_SVH
`define SHA1_CHAIN_LEADING_ZERO_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SCZ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCZ_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCZ_ASSERT(label, clk, rst_n, prop, msg)
`define SCZ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/scz_pkg.sv]
// ----------------------------------------------------------------------------
// scz_pkg
// shared types and constants of the sha1 chain search core
// ----------------------------------------------------------------------------
`default_nettype none
package scz_pkg;
  localparam int WORD_W      = 32;
  localparam int DIGEST_BITS = 160;
  localparam int ROUNDS      = 80;
  localparam int ZB_W        = 8;
  localparam logic [ZB_W-1:0] ZB_RESET = 8'd13;
  localparam logic [31:0] MSG_PAD = 32'h8000_0000;
  localparam logic [31:0] MSG_LEN = 32'd160;
  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;
  localparam logic [0:0] REG_ZERO_BITS = 1'b0;

  typedef logic [WORD_W-1:0] word_t;
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    word_t w4;
  } digest_t;

  // round-side control from the sequencer to the cells
  typedef struct packed {
    logic       load;
    logic       shift;
    logic [6:0] rnd;
  } round_ctl_t;
endpackage
`default_nettype wire

[sv/scz_if.sv]
// ----------------------------------------------------------------------------
// scz_digest_if
// valid/ready channel carrying five digest words
// ----------------------------------------------------------------------------
`default_nettype none
interface scz_digest_if import scz_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t word0;
  word_t word1;
  word_t word2;
  word_t word3;
  word_t word4;
  modport source (output valid, output word0, output word1, output word2,
    output word3, output word4, input ready);
  modport sink (input valid, input word0, input word1, input word2,
    input word3, input word4, output ready);
endinterface
`default_nettype wire

[sv/sha1_chain_leading_zero_search_core.sv]
// ----------------------------------------------------------------------------
// sha1_chain_leading_zero_search_core
// repeated sha1 of a 160-bit digest until enough leading zero bits appear
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries a starting digest as five big-endian words; out_ch returns
//   the first chained digest with at least zero_bits_needed leading zeros.
//   zero_bits_needed sits at apb address 0 (reset 13, values above 160 act
//   as 160). one item is worked at a time.
// sequence:
//   each hash runs a load state, then the rounds of the one-round-per-cycle
//   sha1 datapath, then a check state; a search chains n hashes, n being
//   the chain length (about 2^threshold on average), and the next request is
//   taken in the idle state entered after the final check.
// reset:
//   rst_n low returns the sequencer to idle and the threshold to 13.
// stall:
//   the result stays in the output register until out_ch takes it; the next
//   request is accepted while it waits, and a search that finishes before
//   the old result is taken holds in its check cycle, stalling the input.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_chain_leading_zero_search_core_defines.svh"
module sha1_chain_leading_zero_search_core import scz_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  scz_digest_if.sink   in_ch,
  scz_digest_if.source out_ch,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [0:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [1:0] S_IDLE = 2'd0, S_LOAD = 2'd1, S_RUN = 2'd2, S_CHK = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [6:0]      rnd_r, rnd_nxt;
  logic [ZB_W-1:0] zb_r;
  digest_t         cur_r, res_r, dig;
  logic            out_v_r;
  round_ctl_t      ctl;
  logic [7:0]      lz, need;
  logic            wait_out;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {24'd0, zb_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zb_r <= ZB_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_ZERO_BITS) begin
      zb_r <= cfg_pwdata[7:0];
    end
  end

  scz_round u_round (.clk(clk), .ctl(ctl), .msg(cur_r), .digest(dig));

  // leading zero count over 160 bits, msb first
  always_comb begin
    logic [159:0] v;
    v = dig;
    lz = 8'd160;
    for (int i = 0; i < 160; i++) begin
      if (v[i]) lz = 8'(159 - i);
    end
    need = (zb_r > 8'd160) ? 8'd160 : zb_r;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign wait_out = out_v_r && !out_ch.ready;
  assign ctl.load  = (state_r == S_LOAD);
  assign ctl.shift = (state_r == S_RUN);
  assign ctl.rnd   = rnd_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_LOAD;
      S_LOAD: begin
        state_nxt = S_RUN;
        rnd_nxt = '0;
      end
      S_RUN: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) begin
          state_nxt = S_CHK;
          rnd_nxt = '0;
        end
      end
      S_CHK: begin
        if (lz < need) state_nxt = S_LOAD;
        else if (!wait_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      if (state_r == S_CHK && lz >= need && !wait_out) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cur_r <= {in_ch.word0, in_ch.word1, in_ch.word2, in_ch.word3, in_ch.word4};
    end else if (state_r == S_CHK) begin
      cur_r <= dig;
    end
    if (state_r == S_CHK && lz >= need && !wait_out) res_r <= dig;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.word0 = res_r.w0;
  assign out_ch.word1 = res_r.w1;
  assign out_ch.word2 = res_r.w2;
  assign out_ch.word3 = res_r.w3;
  assign out_ch.word4 = res_r.w4;

  `SCZ_ASSERT(a_rnd_range, clk, rst_n, (rnd_r < 7'(ROUNDS)), "round count out of range")
  `SCZ_ASSERT(a_ready_idle, clk, rst_n, (in_ch.ready |-> !ctl.shift), "accepting while running")
  `SCZ_ASSERT(a_load_run, clk, rst_n, (ctl.load |=> ctl.shift), "load not followed by rounds")
endmodule
`default_nettype wire

[sv/scz_sched_cell.sv]
// ----------------------------------------------------------------------------
// scz_sched_cell
// one word of the message schedule shift chain
// ----------------------------------------------------------------------------
`default_nettype none
module scz_sched_cell import scz_pkg::*; (
  input  wire             clk,
  input  wire round_ctl_t ctl,
  input  wire word_t      load_val,
  input  wire word_t      shift_in,
  output word_t           q
);
  word_t w_r;
  // load on block start, take the neighbor word while shifting, else hold
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      w_r <= load_val;
    end else if (ctl.shift) begin
      w_r <= shift_in;
    end
  end
  assign q = w_r;
endmodule
`default_nettype wire

[sv/scz_round.sv]
// ----------------------------------------------------------------------------
// scz_round
// sixteen-cell message schedule chain plus one sha1 round per cycle while shifting
// ----------------------------------------------------------------------------
`default_nettype none
module scz_round import scz_pkg::*; (
  input  wire             clk,
  input  wire round_ctl_t ctl,
  input  wire digest_t    msg,
  output digest_t         digest
);
  word_t cell_q [16];
  word_t cell_ld [16];
  word_t cell_in [16];
  word_t w_new;
  word_t a_r, b_r, c_r, d_r, e_r;
  word_t f, k, t;

  // schedule words: new word enters at the tail, head is the current round
  assign w_new = {(cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0])} << 1
    | {31'd0, (cell_q[13][31] ^ cell_q[8][31] ^ cell_q[2][31] ^ cell_q[0][31])};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      cell_ld[i] = '0;
      cell_in[i] = (i == 15) ? w_new : cell_q[(i + 1) % 16];
    end
    cell_ld[0]  = msg.w0;
    cell_ld[1]  = msg.w1;
    cell_ld[2]  = msg.w2;
    cell_ld[3]  = msg.w3;
    cell_ld[4]  = msg.w4;
    cell_ld[5]  = MSG_PAD;
    cell_ld[15] = MSG_LEN;
  end

  for (genvar g = 0; g < 16; g++) begin : g_cell
    scz_sched_cell u_cell (
      .clk(clk), .ctl(ctl), .load_val(cell_ld[g]), .shift_in(cell_in[g]),
      .q(cell_q[g])
    );
  end

  // round function selection
  always_comb begin
    if (ctl.rnd < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = 32'h5A82_7999;
    end else if (ctl.rnd < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = 32'h6ED9_EBA1;
    end else if (ctl.rnd < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = 32'h8F1B_BCDC;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = 32'hCA62_C1D6;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + cell_q[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= H0; b_r <= H1; c_r <= H2; d_r <= H3; e_r <= H4;
    end else if (ctl.shift) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t;
    end
  end

  assign digest.w0 = H0 + a_r;
  assign digest.w1 = H1 + b_r;
  assign digest.w2 = H2 + c_r;
  assign digest.w3 = H3 + d_r;
  assign digest.w4 = H4 + e_r;
endmodule
`default_nettype wire

[bench/sha1_chain_search_checker.sv]
// ----------------------------------------------------------------------------
// sha1_chain_search_checker
// watches the digest channels and the apb port, predicts each found digest
// by running the hash chain itself, and compares results in order
// ----------------------------------------------------------------------------
module sha1_chain_search_checker import scz_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  scz_digest_if       in_ch,
  scz_digest_if       out_ch,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [0:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  input  wire         cfg_pready,
  output int          fail_count,
  output int          digests_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ZB_W-1:0] zero_bits_req;
  digest_t found_mem [256];
  int      wr_cnt;
  int      rd_cnt;

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one sha1 compression of a 20-byte message, single padded block
  function automatic digest_t hash_digest(digest_t src);
    word_t sched[80];
    word_t a, b, c, d, e, f, k, t;
    sched[0] = src.w0;
    sched[1] = src.w1;
    sched[2] = src.w2;
    sched[3] = src.w3;
    sched[4] = src.w4;
    sched[5] = 32'h8000_0000;
    for (int i = 6; i < 15; i++) sched[i] = '0;
    sched[15] = 32'd160;
    for (int i = 16; i < 80; i++)
      sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    a = 32'h6745_2301;
    b = 32'hEFCD_AB89;
    c = 32'h98BA_DCFE;
    d = 32'h1032_5476;
    e = 32'hC3D2_E1F0;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      t = rotl(a, 5) + f + e + k + sched[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    return '{32'h6745_2301 + a, 32'hEFCD_AB89 + b, 32'h98BA_DCFE + c,
             32'h1032_5476 + d, 32'hC3D2_E1F0 + e};
  endfunction

  // leading zeros over all 160 bits, word 0 msb first
  function automatic int count_lead_zeros(digest_t v);
    logic [159:0] bits;
    int n;
    bits = v;
    n = 0;
    while (n < 160 && !bits[159 - n]) n++;
    return n;
  endfunction

  // chain hashes until the threshold is met, at least one hash
  function automatic digest_t search_chain(digest_t start, int need);
    digest_t cur;
    if (need > 160) need = 160;
    cur = start;
    do cur = hash_digest(cur); while (count_lead_zeros(cur) < need);
    return cur;
  endfunction

  task automatic check_word(string name, word_t exp_w, word_t act_w);
    if (exp_w !== act_w) begin
      $error("%s mismatch: expected %h actual %h", name, exp_w, act_w);
      fail_count++;
    end
  endtask

  assign digests_pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    digest_t start, exp_d;
    if (!rst_n) begin
      zero_bits_req <= ZB_RESET;
    end else begin
      // threshold write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_ZERO_BITS)
        zero_bits_req <= cfg_pwdata[ZB_W-1:0];
      // accepted request
      if (in_ch.valid && in_ch.ready) begin
        start = '{in_ch.word0, in_ch.word1, in_ch.word2, in_ch.word3, in_ch.word4};
        found_mem[wr_cnt % 256] = search_chain(start, int'(zero_bits_req));
        wr_cnt++;
      end
      // returned digest
      if (out_ch.valid && out_ch.ready) begin
        if (wr_cnt == rd_cnt) begin
          $error("unexpected result digest %h", out_ch.word0);
          fail_count++;
        end else begin
          exp_d = found_mem[rd_cnt % 256];
          rd_cnt++;
          check_word("out_word0", exp_d.w0, out_ch.word0);
          check_word("out_word1", exp_d.w1, out_ch.word1);
          check_word("out_word2", exp_d.w2, out_ch.word2);
          check_word("out_word3", exp_d.w3, out_ch.word3);
          check_word("out_word4", exp_d.w4, out_ch.word4);
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives starting digests and threshold settings into the sha1 chain search
// core; small thresholds keep chains short, with random handshake gaps, a
// long result hold-off and a checker that predicts every found digest
// ----------------------------------------------------------------------------
module testbench import scz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          digests_pending;
  int          cycle_count;
  bit          steady;
  bit          hold_go;
  bit          hold_done;
  int          hold_left;

  scz_digest_if in_ch();
  scz_digest_if out_ch();

  sha1_chain_leading_zero_search_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sha1_chain_search_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .digests_pending(digests_pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
  end
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  task automatic write_threshold(logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_ZERO_BITS;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request, in some calls after a random gap unless steady is set
  task automatic send_digest(digest_t d);
    if (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word0 <= d.w0;
    in_ch.word1 <= d.w1;
    in_ch.word2 <= d.w2;
    in_ch.word3 <= d.w3;
    in_ch.word4 <= d.w4;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic digest_t rand_digest();
    return '{$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // let every request finish, then settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (digests_pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int threshold, int count);
    write_threshold(threshold);
    repeat (count) send_digest(rand_digest());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.word0 = '0;
    in_ch.word1 = '0;
    in_ch.word2 = '0;
    in_ch.word3 = '0;
    in_ch.word4 = '0;
    steady = 1'b0;
    hold_go = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top of the register range and the clamp point; no request can run there
    write_threshold(32'd255);
    write_threshold(32'd160);

    // zero threshold: one hash per request; field extremes, long result hold
    write_threshold(32'd0);
    hold_go <= 1'b1;
    send_digest('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    send_digest('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF});
    send_digest('{32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h1});
    send_digest('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555});
    send_digest('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA});
    send_digest('{32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476,
                  32'hC3D2_E1F0});
    repeat (8) send_digest(rand_digest());
    drain();

    // longer chains; one stretch without any idling
    steady = 1'b1;
    random_phase(1, 20);
    steady = 1'b0;
    random_phase(2, 15);
    random_phase(3, 20);
    random_phase(4, 15);
    random_phase(5, 15);
    random_phase(6, 10);
    random_phase(7, 4);
    random_phase(9, 1);

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
